// ----- design/uer_pkg.sv -----
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger package
// Shared types, register indexes and constants of the echo ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

    localparam int TRIGGER_TICKS_DEF = 10;
    localparam int SETTLE_TICKS_DEF  = 2;
    localparam int COUNTER_BITS_DEF  = 20;

    localparam int TMO_W      = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam int DIST_W = 18;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // Millimetres: width * MM_NUM / MM_DEN. Centimetres: width / CM_DIV.
    localparam int MM_NUM   = 17190;
    localparam int MM_DEN   = 100000;
    localparam int MM_REM_W = $clog2(MM_DEN);
    localparam int CM_DIV   = 58;
    localparam int CM_REM_W = $clog2(CM_DIV);

    localparam logic [TMO_W-1:0] TMO_RESET = TMO_W'(500000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UNIT_MODE    = 3'd0,
        CFG_RISE_TIMEOUT = 3'd1,
        CFG_HIGH_TIMEOUT = 3'd2,
        CFG_SHARED_PIN   = 3'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_SETTLE = 3'd1,
        PH_PULSE  = 3'd2,
        PH_WAIT   = 3'd3,
        PH_HIGH   = 3'd4
    } t_phase;

    typedef struct packed {
        logic start_request;
        logic echo_level;
    } t_in_item;

    typedef struct packed {
        logic              trigger_level;
        logic              drive_enable;
        logic              busy_res;
        logic              done_res;
        logic [DIST_W-1:0] distance;
        logic              timed_out;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } t_cfg_wr;

    typedef struct packed {
        logic             unit_mode;
        logic [TMO_W-1:0] rise_timeout;
        logic [TMO_W-1:0] high_timeout;
        logic             shared_pin;
    } t_cfg;

    // Control from the sequencer to the distance accumulators.
    typedef struct packed {
        logic load;
        logic step;
    } t_dist_ctl;

endpackage

// ----- design/uer_ifs.sv -----
// ----------------------------------------------------------------------------
// Echo ranger channel interfaces
// Valid/ready channels for tick input, result output and register writes.
// ----------------------------------------------------------------------------
interface uer_in_if;
    import uer_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface uer_out_if;
    import uer_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface uer_cfg_if;
    import uer_pkg::*;
    logic    valid;
    logic    ready;
    t_cfg_wr data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- design/uer_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Echo ranger register file
// Holds the four configuration registers; writes to other indexes are dropped.
// ----------------------------------------------------------------------------
module uer_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    uer_cfg_if.sink       i_cfg,
    output uer_pkg::t_cfg o_cfg
);
    import uer_pkg::*;

    t_cfg r_cfg;
    logic wr;

    assign i_cfg.ready = 1'b1;
    assign wr          = i_cfg.valid && i_cfg.ready;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.unit_mode    <= 1'b0;
            r_cfg.rise_timeout <= TMO_RESET;
            r_cfg.high_timeout <= TMO_RESET;
            r_cfg.shared_pin   <= 1'b1;
        end else if (wr) begin
            case (i_cfg.data.index)
                CFG_UNIT_MODE:    r_cfg.unit_mode    <= i_cfg.data.value[0];
                CFG_RISE_TIMEOUT: r_cfg.rise_timeout <= i_cfg.data.value[TMO_W-1:0];
                CFG_HIGH_TIMEOUT: r_cfg.high_timeout <= i_cfg.data.value[TMO_W-1:0];
                CFG_SHARED_PIN:   r_cfg.shared_pin   <= i_cfg.data.value[0];
                default: ;
            endcase
        end
    end

endmodule

// ----- design/uer_dist.sv -----
// ----------------------------------------------------------------------------
// Echo ranger distance accumulators
// Keeps the distance of the current echo width in both units as it grows.
// ----------------------------------------------------------------------------
module uer_dist (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_unit_mode,
    input  uer_pkg::t_dist_ctl          i_ctl,
    output logic [uer_pkg::DIST_W-1:0]  o_distance
);
    import uer_pkg::*;

    // Quotient and remainder of width*MM_NUM/MM_DEN and of width/CM_DIV, so
    // each extra tick of echo costs one add and one compare.
    logic [DIST_W-1:0]   r_mm_q, n_mm_q;
    logic [MM_REM_W-1:0] r_mm_r, n_mm_r;
    logic [DIST_W-1:0]   r_cm_q, n_cm_q;
    logic [CM_REM_W-1:0] r_cm_r, n_cm_r;
    logic [MM_REM_W:0]   mm_sum;

    assign mm_sum     = {1'b0, r_mm_r} + (MM_REM_W+1)'(MM_NUM);
    assign o_distance = i_unit_mode ? r_cm_q : r_mm_q;

    always_comb begin
        n_mm_q = r_mm_q;
        n_mm_r = r_mm_r;
        n_cm_q = r_cm_q;
        n_cm_r = r_cm_r;
        if (i_ctl.load) begin
            n_mm_q = '0;
            n_mm_r = MM_REM_W'(MM_NUM);
            n_cm_q = '0;
            n_cm_r = CM_REM_W'(1);
        end else if (i_ctl.step) begin
            if (mm_sum >= (MM_REM_W+1)'(MM_DEN)) begin
                n_mm_r = MM_REM_W'(mm_sum - (MM_REM_W+1)'(MM_DEN));
                if (r_mm_q != DIST_MAX) begin
                    n_mm_q = r_mm_q + DIST_W'(1);
                end
            end else begin
                n_mm_r = mm_sum[MM_REM_W-1:0];
            end
            if (r_cm_r == CM_REM_W'(CM_DIV - 1)) begin
                n_cm_r = '0;
                if (r_cm_q != DIST_MAX) begin
                    n_cm_q = r_cm_q + DIST_W'(1);
                end
            end else begin
                n_cm_r = r_cm_r + CM_REM_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mm_q <= '0;
            r_mm_r <= '0;
            r_cm_q <= '0;
            r_cm_r <= '0;
        end else begin
            r_mm_q <= n_mm_q;
            r_mm_r <= n_mm_r;
            r_cm_q <= n_cm_q;
            r_cm_r <= n_cm_r;
        end
    end

    a_mm_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mm_r < MM_REM_W'(MM_DEN))
        else $error("millimetre remainder out of range");

    a_cm_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cm_r < CM_REM_W'(CM_DIV))
        else $error("centimetre remainder out of range");

    a_load_width_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.load |=> r_cm_r == CM_REM_W'(1) && r_mm_r == MM_REM_W'(MM_NUM))
        else $error("load did not start from a width of one tick");

endmodule

// ----- design/uer_core.sv -----
// ----------------------------------------------------------------------------
// Echo ranger sequencer
// Phase machine that turns one tick into one result and keeps the counters.
// ----------------------------------------------------------------------------
module uer_core #(
    parameter int TRIGGER_TICKS = uer_pkg::TRIGGER_TICKS_DEF,
    parameter int SETTLE_TICKS  = uer_pkg::SETTLE_TICKS_DEF,
    parameter int COUNTER_BITS  = uer_pkg::COUNTER_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  uer_pkg::t_in_item          i_item,
    input  uer_pkg::t_cfg              i_cfg,
    input  logic [uer_pkg::DIST_W-1:0] i_distance,
    output uer_pkg::t_dist_ctl         o_dist_ctl,
    output uer_pkg::t_out_item         o_result
);
    import uer_pkg::*;

    localparam int CMP_W = (COUNTER_BITS > TMO_W) ? COUNTER_BITS : TMO_W;
    localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

    t_phase                  r_phase, n_phase, cur_phase;
    logic [COUNTER_BITS-1:0] r_phase_ticks, n_phase_ticks, cur_ticks, ticks_inc;
    logic [COUNTER_BITS-1:0] r_echo_width, n_echo_width, width_inc;
    logic [CMP_W-1:0]        lim_rise, lim_high, rise_ext, high_ext;
    logic                    start_now, dist_load, dist_step;

    assign start_now = (r_phase == PH_IDLE) && i_item.start_request;
    assign cur_phase = start_now ? PH_SETTLE : r_phase;
    assign cur_ticks = start_now ? '0 : r_phase_ticks;
    assign ticks_inc = (cur_ticks == CNT_MAX) ? cur_ticks : cur_ticks + COUNTER_BITS'(1);
    assign width_inc = (r_echo_width == CNT_MAX) ? r_echo_width
                                                 : r_echo_width + COUNTER_BITS'(1);

    // A timeout of zero acts as one, any above the counter range as its maximum.
    assign rise_ext = CMP_W'(i_cfg.rise_timeout);
    assign high_ext = CMP_W'(i_cfg.high_timeout);
    assign lim_rise = (rise_ext == '0) ? CMP_W'(1)
                    : (rise_ext > CMP_W'(CNT_MAX)) ? CMP_W'(CNT_MAX) : rise_ext;
    assign lim_high = (high_ext == '0) ? CMP_W'(1)
                    : (high_ext > CMP_W'(CNT_MAX)) ? CMP_W'(CNT_MAX) : high_ext;

    assign o_dist_ctl.load = i_step && dist_load;
    assign o_dist_ctl.step = i_step && dist_step;

    always_comb begin
        n_phase       = cur_phase;
        n_phase_ticks = cur_ticks;
        n_echo_width  = start_now ? '0 : r_echo_width;
        dist_load     = 1'b0;
        dist_step     = 1'b0;
        o_result               = '0;
        o_result.drive_enable  = ~i_cfg.shared_pin;
        o_result.busy_res      = 1'b1;
        case (cur_phase)
            PH_SETTLE: begin
                o_result.drive_enable = 1'b1;
                n_phase_ticks = ticks_inc;
                if (ticks_inc >= COUNTER_BITS'(SETTLE_TICKS)) begin
                    n_phase       = PH_PULSE;
                    n_phase_ticks = '0;
                end
            end
            PH_PULSE: begin
                o_result.trigger_level = 1'b1;
                o_result.drive_enable  = 1'b1;
                n_phase_ticks = ticks_inc;
                if (ticks_inc >= COUNTER_BITS'(TRIGGER_TICKS)) begin
                    n_phase       = PH_WAIT;
                    n_phase_ticks = '0;
                end
            end
            PH_WAIT: begin
                if (i_item.echo_level) begin
                    // The rising tick already counts as one tick of width.
                    n_echo_width  = COUNTER_BITS'(1);
                    n_phase_ticks = '0;
                    dist_load     = 1'b1;
                    if (lim_high == CMP_W'(1)) begin
                        o_result.done_res  = 1'b1;
                        o_result.timed_out = 1'b1;
                        n_phase            = PH_IDLE;
                    end else begin
                        n_phase = PH_HIGH;
                    end
                end else begin
                    n_phase_ticks = ticks_inc;
                    if (CMP_W'(ticks_inc) >= lim_rise) begin
                        o_result.done_res  = 1'b1;
                        o_result.timed_out = 1'b1;
                        n_phase            = PH_IDLE;
                        n_phase_ticks      = '0;
                    end
                end
            end
            PH_HIGH: begin
                if (i_item.echo_level) begin
                    n_echo_width = width_inc;
                    dist_step    = (r_echo_width != CNT_MAX);
                    if (CMP_W'(width_inc) >= lim_high) begin
                        o_result.done_res  = 1'b1;
                        o_result.timed_out = 1'b1;
                        n_phase            = PH_IDLE;
                    end
                end else begin
                    o_result.done_res = 1'b1;
                    o_result.distance = i_distance;
                    n_phase           = PH_IDLE;
                end
            end
            default: begin
                n_phase           = PH_IDLE;
                o_result.busy_res = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_phase_ticks <= '0;
            r_echo_width  <= '0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_phase_ticks <= n_phase_ticks;
            r_echo_width  <= n_echo_width;
        end
    end

    a_high_has_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HIGH |-> r_echo_width != '0)
        else $error("echo high phase with zero width");

    a_idle_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_result.done_res |=> r_phase == PH_IDLE)
        else $error("phase not idle after a done tick");

    a_hold_without_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_phase) && $stable(r_echo_width))
        else $error("sequencer state moved without a tick");

endmodule

// ----- design/ultrasonic_echo_ranger.sv -----
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger
// Trigger, echo timing and distance conversion for a pulse-echo range sensor.
// ----------------------------------------------------------------------------
// Each input beat is one microsecond tick with a start request and the sampled
// echo level, and it yields exactly one result beat. The block takes a tick in
// every cycle while the result register is empty or being read out; the single
// phase update per tick sets that rate. A tick is held in the input register,
// and its result then in the result register. The echo width is converted
// while it is counted, so the distance is ready on the falling tick in either
// unit. Register writes are always accepted and must only be made when no
// measurement is in progress.
module ultrasonic_echo_ranger #(
    parameter int TRIGGER_TICKS = uer_pkg::TRIGGER_TICKS_DEF,
    parameter int SETTLE_TICKS  = uer_pkg::SETTLE_TICKS_DEF,
    parameter int COUNTER_BITS  = uer_pkg::COUNTER_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    uer_in_if.sink    i_in,
    uer_cfg_if.sink   i_cfg,
    uer_out_if.source o_out
);
    import uer_pkg::*;

    logic              r_in_valid;
    t_in_item          r_in_item;
    logic              r_out_valid;
    t_out_item         r_out_item;
    logic              advance;
    t_cfg              cfg;
    t_dist_ctl         dist_ctl;
    logic [DIST_W-1:0] distance;
    t_out_item         result;

    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_item;

    uer_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    uer_dist u_dist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_unit_mode (cfg.unit_mode),
        .i_ctl       (dist_ctl),
        .o_distance  (distance)
    );

    uer_core #(
        .TRIGGER_TICKS (TRIGGER_TICKS),
        .SETTLE_TICKS  (SETTLE_TICKS),
        .COUNTER_BITS  (COUNTER_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (advance),
        .i_item     (r_in_item),
        .i_cfg      (cfg),
        .i_distance (distance),
        .o_dist_ctl (dist_ctl),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_item <= i_in.data;
        end
        if (advance) begin
            r_out_item <= result;
        end
    end

    a_done_is_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_item.done_res |-> r_out_item.busy_res)
        else $error("done beat without busy");

    a_timeout_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_item.timed_out |->
            r_out_item.done_res && r_out_item.distance == '0)
        else $error("timeout beat with a distance");

    a_trigger_driven: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_item.trigger_level |-> r_out_item.drive_enable)
        else $error("trigger high while the pin is released");

endmodule
